// ----- sv/mrgb_pkg.sv -----
// Shared types, constants and slot map for the multiplexed RGB LED duty controller.
package mrgb_pkg;

	localparam int LED_COUNT     = 6;
	localparam int BANK_CHANNELS = 9;
	localparam int SLOT_COUNT    = 2 * BANK_CHANNELS;
	localparam int RAM_DEPTH     = 2 * SLOT_COUNT;
	localparam int RAM_AW        = $clog2(RAM_DEPTH);
	localparam int DUTY_W        = 15;
	localparam int SLOT_W        = $clog2(SLOT_COUNT);

	localparam logic [DUTY_W-1:0] DUTY_MAX   = 15'h7FFF;
	localparam logic [DUTY_W-1:0] TEST_LEVEL = 15'd32000;
	localparam logic [5:0]        PATTERN_BANK0 = 6'h15;
	localparam logic [5:0]        PATTERN_BANK1 = 6'h2A;
	localparam logic [7:0]        TEST_LED_MASK = 8'hFC;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TICK = 1'b1;
	localparam logic KIND_COMPARE = 1'b0;
	localparam logic KIND_REPORT  = 1'b1;

	typedef enum logic [1:0] {
		COL_RED,
		COL_GREEN,
		COL_BLUE,
		COL_NONE
	} colour_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SWEEP,
		ST_REPORT,
		ST_TICK_RD,
		ST_TICK_OUT
	} state_t;

	typedef struct packed {
		logic              mode;
		logic [2:0]        led_index;
		logic [DUTY_W-1:0] red_level;
		logic [DUTY_W-1:0] green_level;
		logic [DUTY_W-1:0] blue_level;
		logic [DUTY_W-1:0] red_offset;
		logic [DUTY_W-1:0] green_offset;
		logic [DUTY_W-1:0] blue_offset;
		logic              commit;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic [3:0]  channel;
		logic [13:0] compare_value;
		logic [5:0]  switch_pattern;
		logic [17:0] measurable_mask;
		logic        last;
	} result_t;

	// Slot that holds one color of one LED.
	function automatic logic [SLOT_W-1:0] slot_of(input logic [2:0] led, input colour_t col);
		logic [SLOT_W-1:0] base;
		logic [SLOT_W-1:0] offs;
		case (led)
			3'd0: base = 5'd0;
			3'd1: base = 5'd9;
			3'd2: base = 5'd3;
			3'd3: base = 5'd12;
			3'd4: base = 5'd6;
			3'd5: base = 5'd15;
			default: base = 5'd0;
		endcase
		case (col)
			COL_RED:   offs = 5'd1;
			COL_GREEN: offs = 5'd0;
			COL_BLUE:  offs = 5'd2;
			default:   offs = 5'd0;
		endcase
		return base + offs;
	endfunction

	// LED that owns a slot.
	function automatic logic [2:0] slot_led(input logic [SLOT_W-1:0] slot);
		logic [2:0] led;
		case (slot)
			5'd0, 5'd1, 5'd2:    led = 3'd0;
			5'd3, 5'd4, 5'd5:    led = 3'd2;
			5'd6, 5'd7, 5'd8:    led = 3'd4;
			5'd9, 5'd10, 5'd11:  led = 3'd1;
			5'd12, 5'd13, 5'd14: led = 3'd3;
			5'd15, 5'd16, 5'd17: led = 3'd5;
			default:             led = 3'd0;
		endcase
		return led;
	endfunction

	// Color that a slot carries.
	function automatic colour_t slot_colour(input logic [SLOT_W-1:0] slot);
		colour_t col;
		case (slot)
			5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15:  col = COL_GREEN;
			5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16: col = COL_RED;
			5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17: col = COL_BLUE;
			default:                               col = COL_NONE;
		endcase
		return col;
	endfunction

	// Address of a slot within one half of the duty buffer memory.
	function automatic logic [RAM_AW-1:0] half_addr(input logic half, input logic [SLOT_W-1:0] slot);
		return half ? RAM_AW'(slot) + RAM_AW'(SLOT_COUNT) : RAM_AW'(slot);
	endfunction

endpackage

// ----- sv/mrgb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mrgb_ram #(
	parameter int WIDTH = mrgb_pkg::DUTY_W,
	parameter int DEPTH = mrgb_pkg::RAM_DEPTH,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/multiplexed_rgb_led_pwm_duty.sv -----
// Top level of the multiplexed RGB LED duty controller: sequencer, staging store and duty buffers.
//
//   channel  | signals                                   | carries
//   item     | item_valid, item_stall, item              | load or bank tick
//   result   | result_valid, result_stall, result        | compare values or measurable report
//   config   | cfg_wr_en, cfg_wr_data                    | led_test_mask register
//
// After acceptance a load passes red, green and blue in turn through the shared saturating adder.
// A commit adds a sweep over the staging slots (one duty buffer write per cycle), then the
// report. A tick reads the duty buffer memory one channel ahead, then gives one compare value
// per cycle while the result is not stalled. The block takes no new item meanwhile.
// After reset the staging store and both buffers read as zero at once; no clearing pass.
// A stalled result holds the output register and the sequencer waits on it.
module multiplexed_rgb_led_pwm_duty (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  mrgb_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output mrgb_pkg::result_t result,
	input  logic              cfg_wr_en,
	input  logic [7:0]        cfg_wr_data
);

	localparam int SW = mrgb_pkg::SLOT_W;
	localparam int DW = mrgb_pkg::DUTY_W;
	localparam int AW = mrgb_pkg::RAM_AW;
	localparam logic [SW-1:0] LAST_SLOT = SW'(mrgb_pkg::SLOT_COUNT - 1);
	localparam logic [SW-1:0] LAST_CH   = SW'(mrgb_pkg::BANK_CHANNELS - 1);
	localparam logic [SW-1:0] LAST_COL  = SW'(2);

	mrgb_pkg::state_t  state_q, state_d;
	logic [SW-1:0]     cnt_q, cnt_d;
	mrgb_pkg::item_t   item_q;
	logic [7:0]        test_mask_q;
	logic [DW-1:0]     staging_q [mrgb_pkg::SLOT_COUNT];
	logic              active_q;
	logic              phase_q;
	logic [1:0]        half_valid_q;
	logic [17:0]       mask_q;
	logic              result_valid_q;
	mrgb_pkg::result_t result_q;

	logic              accept;
	logic              out_free;
	logic              test_mode;
	logic              sweep_done;
	logic              tick_done;

	logic              stg_we;
	logic [SW-1:0]     stg_slot;
	logic [DW-1:0]     stg_data;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DW-1:0]     ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [DW-1:0]     ram_rdata;
	logic              out_load;
	mrgb_pkg::result_t out_next;

	mrgb_pkg::colour_t load_col;
	logic [DW-1:0]     load_level;
	logic [DW-1:0]     load_offset;
	logic [DW:0]       load_sum;
	logic [DW-1:0]     load_duty;
	logic [DW-1:0]     sweep_val;
	logic [DW-1:0]     test_val;
	logic [2:0]        sweep_led;
	logic [5:0]        test_leds;
	logic [SW-1:0]     rd_ch;
	logic [SW-1:0]     tick_slot;
	logic [DW-1:0]     tick_duty;

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != mrgb_pkg::ST_IDLE);
	assign out_free   = !result_valid_q || !result_stall;
	assign test_mode  = |(test_mask_q & mrgb_pkg::TEST_LED_MASK);
	assign sweep_done = (state_q == mrgb_pkg::ST_SWEEP) && (cnt_q == LAST_SLOT);
	assign tick_done  = (state_q == mrgb_pkg::ST_TICK_OUT) && out_free && (cnt_q == LAST_CH);

	// Shared saturating adder: one color per cycle during a load.
	assign load_col = mrgb_pkg::colour_t'(cnt_q[1:0]);
	always_comb begin
		case (load_col)
			mrgb_pkg::COL_RED: begin
				load_level  = item_q.red_level;
				load_offset = item_q.red_offset;
			end
			mrgb_pkg::COL_GREEN: begin
				load_level  = item_q.green_level;
				load_offset = item_q.green_offset;
			end
			mrgb_pkg::COL_BLUE: begin
				load_level  = item_q.blue_level;
				load_offset = item_q.blue_offset;
			end
			default: begin
				load_level  = '0;
				load_offset = '0;
			end
		endcase
	end
	assign load_sum  = {1'b0, load_level} + {1'b0, load_offset};
	assign load_duty = (load_level == '0) ? '0 :
		(load_sum[DW] ? mrgb_pkg::DUTY_MAX : load_sum[DW-1:0]);

	// Test pattern for the slot under the sweep.
	assign test_leds = test_mask_q[7:2];
	assign sweep_led = mrgb_pkg::slot_led(cnt_q);
	assign test_val  = (test_leds[sweep_led] &&
		(mrgb_pkg::colour_t'(test_mask_q[1:0]) == mrgb_pkg::slot_colour(cnt_q))) ?
		mrgb_pkg::TEST_LEVEL : '0;
	assign sweep_val = test_mode ? test_val : staging_q[cnt_q];

	// The read runs one channel ahead of the output register.
	assign rd_ch     = (state_q == mrgb_pkg::ST_TICK_OUT && out_free && cnt_q != LAST_CH) ?
		SW'(cnt_q + SW'(1)) : cnt_q;
	assign tick_slot = phase_q ? SW'(rd_ch + SW'(mrgb_pkg::BANK_CHANNELS)) : rd_ch;
	assign tick_duty = half_valid_q[active_q] ? ram_rdata : '0;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			mrgb_pkg::ST_IDLE: begin
				cnt_d = '0;
				if (accept) begin
					state_d = (item.mode == mrgb_pkg::MODE_TICK) ?
						mrgb_pkg::ST_TICK_RD : mrgb_pkg::ST_LOAD;
				end
			end
			mrgb_pkg::ST_LOAD: begin
				if (cnt_q == LAST_COL) begin
					cnt_d   = '0;
					state_d = item_q.commit ? mrgb_pkg::ST_SWEEP : mrgb_pkg::ST_IDLE;
				end else begin
					cnt_d = SW'(cnt_q + SW'(1));
				end
			end
			mrgb_pkg::ST_SWEEP: begin
				if (sweep_done) begin
					cnt_d   = '0;
					state_d = mrgb_pkg::ST_REPORT;
				end else begin
					cnt_d = SW'(cnt_q + SW'(1));
				end
			end
			mrgb_pkg::ST_REPORT: begin
				if (out_free) begin
					state_d = mrgb_pkg::ST_IDLE;
				end
			end
			mrgb_pkg::ST_TICK_RD: begin
				state_d = mrgb_pkg::ST_TICK_OUT;
			end
			mrgb_pkg::ST_TICK_OUT: begin
				if (tick_done) begin
					cnt_d   = '0;
					state_d = mrgb_pkg::ST_IDLE;
				end else if (out_free) begin
					cnt_d = SW'(cnt_q + SW'(1));
				end
			end
			default: begin
				state_d = mrgb_pkg::ST_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	always_comb begin
		stg_we    = 1'b0;
		stg_slot  = cnt_q;
		stg_data  = sweep_val;
		ram_we    = 1'b0;
		ram_waddr = mrgb_pkg::half_addr(!active_q, cnt_q);
		ram_wdata = sweep_val;
		ram_raddr = mrgb_pkg::half_addr(active_q, tick_slot);
		out_load  = 1'b0;
		out_next  = '0;
		case (state_q)
			mrgb_pkg::ST_LOAD: begin
				stg_we   = !test_mode && (item_q.led_index < 3'(mrgb_pkg::LED_COUNT));
				stg_slot = mrgb_pkg::slot_of(item_q.led_index, load_col);
				stg_data = load_duty;
			end
			mrgb_pkg::ST_SWEEP: begin
				// In test mode the pattern also overwrites staging.
				stg_we = test_mode;
				ram_we = 1'b1;
			end
			mrgb_pkg::ST_REPORT: begin
				out_load                 = out_free;
				out_next.kind            = mrgb_pkg::KIND_REPORT;
				out_next.measurable_mask = mask_q;
				out_next.last            = 1'b1;
			end
			mrgb_pkg::ST_TICK_OUT: begin
				out_load               = out_free;
				out_next.kind          = mrgb_pkg::KIND_COMPARE;
				out_next.channel       = cnt_q[3:0];
				out_next.compare_value = 14'((mrgb_pkg::DUTY_MAX - tick_duty) >> 1);
				out_next.switch_pattern = phase_q ? mrgb_pkg::PATTERN_BANK1 :
					mrgb_pkg::PATTERN_BANK0;
				out_next.last          = (cnt_q == LAST_CH);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= mrgb_pkg::ST_IDLE;
			cnt_q          <= '0;
			test_mask_q    <= '0;
			active_q       <= 1'b0;
			phase_q        <= 1'b0;
			half_valid_q   <= '0;
			result_valid_q <= 1'b0;
			for (int i = 0; i < mrgb_pkg::SLOT_COUNT; i++) begin
				staging_q[i] <= '0;
			end
		end else begin
			state_q        <= state_d;
			cnt_q          <= cnt_d;
			result_valid_q <= out_load || (result_valid_q && result_stall);
			if (cfg_wr_en) begin
				test_mask_q <= cfg_wr_data;
			end
			if (stg_we) begin
				staging_q[stg_slot] <= stg_data;
			end
			if (sweep_done) begin
				active_q               <= !active_q;
				half_valid_q[!active_q] <= 1'b1;
			end
			if (tick_done) begin
				phase_q <= !phase_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if (state_q == mrgb_pkg::ST_SWEEP) begin
			mask_q[cnt_q] <= (sweep_val != '0);
		end
		if (out_load) begin
			result_q <= out_next;
		end
	end

	mrgb_ram #(
		.WIDTH(mrgb_pkg::DUTY_W),
		.DEPTH(mrgb_pkg::RAM_DEPTH)
	) u_duty_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef NO_ASSERTIONS
	a_report_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == mrgb_pkg::KIND_REPORT |->
		result.last && result.switch_pattern == '0)
		else $error("measurable report without last or with a switch pattern");

	a_compare_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == mrgb_pkg::KIND_COMPARE |->
		result.measurable_mask == '0 &&
		(result.switch_pattern == mrgb_pkg::PATTERN_BANK0 ||
		result.switch_pattern == mrgb_pkg::PATTERN_BANK1))
		else $error("compare result with a stray mask or switch pattern");

	a_phase_flip: assert property (@(posedge clk) disable iff (!arst_n)
		tick_done |=> phase_q != $past(phase_q))
		else $error("bank did not flip after the last compare of a tick");

	a_sweep_commit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mrgb_pkg::ST_SWEEP |->
		item_q.commit && item_q.mode == mrgb_pkg::MODE_LOAD && cnt_q <= LAST_SLOT)
		else $error("buffer sweep without a committing load");
`endif

endmodule

// ----- verif/mrgb_duty_checker.sv -----
// Checker that predicts and compares the outputs of the multiplexed RGB LED duty controller.
module mrgb_duty_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_stall,
	input  mrgb_pkg::item_t   item,
	input  logic              result_valid,
	input  logic              result_stall,
	input  mrgb_pkg::result_t result,
	input  logic              cfg_wr_en,
	input  logic [7:0]        cfg_wr_data,
	output int                mismatch_count,
	output int                outputs_awaited
);
	import mrgb_pkg::*;

	logic [DUTY_W-1:0] staging [SLOT_COUNT];
	logic [DUTY_W-1:0] duty_buf [2][SLOT_COUNT];
	logic              active_half;
	logic              bank_sel;
	logic [7:0]        led_test_mask;
	result_t           awaited_outputs [$];
	result_t           oldest;

	function automatic int slot_for(input int led, input colour_t col);
		int offs;
		case (col)
			COL_RED:  offs = 1;
			COL_BLUE: offs = 2;
			default:  offs = 0;
		endcase
		// Odd LEDs sit in the second bank, and each LED takes three slots in its bank.
		return (led % 2) * BANK_CHANNELS + (led / 2) * 3 + offs;
	endfunction

	function automatic logic [DUTY_W-1:0] compensated(input logic [DUTY_W-1:0] lv,
	                                                  input logic [DUTY_W-1:0] off);
		logic [DUTY_W:0] sum;
		sum = {1'b0, lv} + {1'b0, off};
		if (lv == '0)
			return '0;
		if (sum > {1'b0, DUTY_MAX})
			return DUTY_MAX;
		return sum[DUTY_W-1:0];
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic advance_duty_state(input item_t it);
		result_t           r;
		logic [DUTY_W-1:0] diff;
		logic              test_on;
		logic              idle;
		colour_t           test_col;
		logic [17:0]       mask;
		int                base;
		test_on = |(led_test_mask & TEST_LED_MASK);
		if (it.mode == MODE_TICK) begin
			base = bank_sel ? BANK_CHANNELS : 0;
			for (int ch = 0; ch < BANK_CHANNELS; ch++) begin
				diff = DUTY_MAX - duty_buf[active_half][base + ch];
				r = '0;
				r.kind = KIND_COMPARE;
				r.channel = 4'(ch);
				r.compare_value = diff[DUTY_W-1:1];
				r.switch_pattern = bank_sel ? PATTERN_BANK1 : PATTERN_BANK0;
				r.last = (ch == BANK_CHANNELS - 1);
				awaited_outputs.push_back(r);
			end
			bank_sel = ~bank_sel;
		end else begin
			if (!test_on && it.led_index < LED_COUNT) begin
				staging[slot_for(it.led_index, COL_RED)] = compensated(it.red_level, it.red_offset);
				staging[slot_for(it.led_index, COL_GREEN)] =
					compensated(it.green_level, it.green_offset);
				staging[slot_for(it.led_index, COL_BLUE)] =
					compensated(it.blue_level, it.blue_offset);
			end
			if (it.commit) begin
				if (test_on) begin
					test_col = colour_t'(led_test_mask[1:0]);
					for (int led = 0; led < LED_COUNT; led++) begin
						for (int c = 0; c < 3; c++) begin
							staging[slot_for(led, colour_t'(c))] =
								(led_test_mask[led + 2] && test_col == colour_t'(c)) ?
								TEST_LEVEL : '0;
						end
					end
				end
				idle = ~active_half;
				mask = '0;
				for (int s = 0; s < SLOT_COUNT; s++) begin
					duty_buf[idle][s] = staging[s];
					mask[s] = (staging[s] != '0);
				end
				active_half = idle;
				r = '0;
				r.kind = KIND_REPORT;
				r.measurable_mask = mask;
				r.last = 1'b1;
				awaited_outputs.push_back(r);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SLOT_COUNT; s++) begin
				staging[s] = '0;
				duty_buf[0][s] = '0;
				duty_buf[1][s] = '0;
			end
			active_half = 1'b0;
			bank_sel = 1'b0;
			led_test_mask = '0;
			awaited_outputs.delete();
			mismatch_count = 0;
			outputs_awaited <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (awaited_outputs.size() == 0) begin
					$display("%0t unexpected result: expected none, actual %h", $time, result);
					mismatch_count++;
				end else begin
					oldest = awaited_outputs.pop_front();
					check_field("kind", oldest.kind, result.kind);
					check_field("channel", oldest.channel, result.channel);
					check_field("compare_value", oldest.compare_value, result.compare_value);
					check_field("switch_pattern", oldest.switch_pattern, result.switch_pattern);
					check_field("measurable_mask", oldest.measurable_mask,
					            result.measurable_mask);
					check_field("last", oldest.last, result.last);
				end
			end
			if (cfg_wr_en)
				led_test_mask = cfg_wr_data;
			if (item_valid && !item_stall)
				advance_duty_state(item);
			outputs_awaited <= awaited_outputs.size();
		end
	end

endmodule

// ----- verif/multiplexed_rgb_led_pwm_duty_tb.sv -----
// Testbench top for the multiplexed RGB LED duty controller: stimulus, stalls and verdict.
module multiplexed_rgb_led_pwm_duty_tb;
	import mrgb_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_stall;
	item_t      item = '0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	result_t    result;
	logic       cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = '0;
	int         mismatch_count;
	int         outputs_awaited;
	int         stall_left = 0;
	int         stall_draw;
	bit         quiet = 1'b0;
	int         sent = 0;

	always #2 clk = ~clk;

	multiplexed_rgb_led_pwm_duty u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	mrgb_duty_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.item            (item),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.result          (result),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.mismatch_count  (mismatch_count),
		.outputs_awaited (outputs_awaited)
	);

	// After each accepted result the receiver holds off for a random number of cycles.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result_stall <= (stall_left > 1);
		end else if (result_valid && !result_stall) begin
			stall_draw = quiet ? 0 : $urandom_range(0, 5);
			stall_left <= stall_draw;
			result_stall <= (stall_draw != 0);
		end
	end

	initial begin
		#(1_000_000);
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [DUTY_W-1:0] pick_level();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return DUTY_MAX;
			2:       return DUTY_W'($urandom_range(1, 4));
			default: return DUTY_W'($urandom);
		endcase
	endfunction

	function automatic logic [DUTY_W-1:0] pick_offset();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return DUTY_MAX;
			2, 3:    return DUTY_W'($urandom_range(0, 255));
			default: return DUTY_W'($urandom);
		endcase
	endfunction

	function automatic item_t load_set(input logic [2:0] led,
	                                   input logic [DUTY_W-1:0] r, g, b, ro, go, bo,
	                                   input logic cm);
		item_t it;
		it.mode = MODE_LOAD;
		it.led_index = led;
		it.red_level = r;
		it.green_level = g;
		it.blue_level = b;
		it.red_offset = ro;
		it.green_offset = go;
		it.blue_offset = bo;
		it.commit = cm;
		return it;
	endfunction

	// Tick items carry random junk in the fields the block ignores, commit included.
	function automatic item_t tick_of();
		logic [127:0] raw;
		item_t        it;
		raw = {$urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(item_t)-1:0];
		it.mode = MODE_TICK;
		return it;
	endfunction

	task automatic send(input item_t it);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		sent++;
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outputs_awaited != 0) @(posedge clk);
		// A load without commit leaves no output behind, so give it time to drain.
		repeat (30) @(posedge clk);
	endtask

	task automatic write_mask(input logic [7:0] m);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Mostly loads to a few LEDs closed by a commit and followed by ticks, with some noise.
	task automatic run_sequence();
		int           loads;
		int           ticks;
		logic [2:0]   led;
		logic         cm;
		logic [127:0] raw;
		item_t        it;
		if ($urandom_range(0, 9) == 0) begin
			raw = {$urandom, $urandom, $urandom, $urandom};
			it = raw[$bits(item_t)-1:0];
			send(it);
		end else begin
			loads = $urandom_range(1, 6);
			for (int k = 0; k < loads; k++) begin
				led = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) :
				      3'($urandom_range(0, 5));
				cm = (k == loads - 1) && ($urandom_range(0, 3) != 0);
				send(load_set(led, pick_level(), pick_level(), pick_level(),
				              pick_offset(), pick_offset(), pick_offset(), cm));
			end
			ticks = $urandom_range(0, 4);
			repeat (ticks) send(tick_of());
		end
	endtask

	initial begin
		item_t tick_commit;
		int    start;
		logic [7:0] phase_mask;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		write_mask(8'h00);
		// Both banks read back as zero duty right after reset.
		send(tick_of());
		send(tick_of());
		send(load_set(3'd0, DUTY_MAX, DUTY_MAX, DUTY_MAX, DUTY_MAX, DUTY_MAX, DUTY_MAX, 1'b0));
		send(load_set(3'd1, 15'h0, 15'h0, 15'h0, DUTY_MAX, DUTY_MAX, DUTY_MAX, 1'b0));
		send(load_set(3'd2, 15'h1, DUTY_MAX, 15'h4000, 15'h0, 15'h0, 15'h4000, 1'b0));
		send(load_set(3'd3, 15'h1, 15'h7FFE, 15'h2AAA, 15'h7FFE, 15'h1, 15'h1555, 1'b0));
		send(load_set(3'd4, 15'h5555, 15'h2AAA, 15'h1, 15'h2AAA, 15'h5555, 15'h0, 1'b0));
		send(load_set(3'd5, 15'h1234, 15'h0, DUTY_MAX, 15'h0, DUTY_MAX, DUTY_MAX, 1'b1));
		send(tick_of());
		send(tick_of());
		// An LED index past the last LED stores nothing but still commits.
		send(load_set(3'd6, DUTY_MAX, DUTY_MAX, DUTY_MAX, 15'h0, 15'h0, 15'h0, 1'b1));
		send(load_set(3'd7, DUTY_MAX, DUTY_MAX, DUTY_MAX, 15'h0, 15'h0, 15'h0, 1'b0));
		tick_commit = tick_of();
		tick_commit.commit = 1'b1;
		send(tick_commit);

		// All LEDs selected with color three leaves every slot at zero.
		write_mask(8'hFF);
		send(load_set(3'd0, DUTY_MAX, DUTY_MAX, DUTY_MAX, 15'h0, 15'h0, 15'h0, 1'b0));
		send(load_set(3'd2, DUTY_MAX, DUTY_MAX, DUTY_MAX, 15'h0, 15'h0, 15'h0, 1'b1));
		send(tick_of());
		write_mask(8'hFC);
		send(load_set(3'd1, 15'h10, 15'h10, 15'h10, 15'h0, 15'h0, 15'h0, 1'b1));
		send(tick_of());
		send(tick_of());
		write_mask(8'h05);
		send(load_set(3'd7, 15'h10, 15'h10, 15'h10, 15'h0, 15'h0, 15'h0, 1'b1));
		send(tick_of());
		write_mask(8'h82);
		send(load_set(3'd5, 15'h10, 15'h10, 15'h10, 15'h0, 15'h0, 15'h0, 1'b1));
		send(tick_of());
		// Color bits alone do not enable test mode.
		write_mask(8'h03);
		send(load_set(3'd4, 15'h100, 15'h200, 15'h300, 15'h7F00, 15'h7F00, 15'h7F00, 1'b1));
		send(tick_of());

		for (int p = 0; p < 8; p++) begin
			case (p)
				1, 5:    phase_mask = 8'($urandom);
				3:       phase_mask = 8'hFF;
				6:       phase_mask = 8'hFC;
				7:       phase_mask = 8'h03;
				default: phase_mask = 8'h00;
			endcase
			write_mask(phase_mask);
			quiet = (p % 3 == 1);
			start = sent;
			while (sent - start < 52) run_sequence();
		end

		quiet = 1'b0;
		settle();
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
